### rtl/rc4_pkg.sv
// Shared types and constants of the RC4 stream cipher block.
package rc4_pkg;

   localparam int BYTE_W   = 8;
   localparam int SBOX_AW  = 8;
   localparam int KEY_LEN_W = 9;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 9'd16;

   // Opcodes of the input item.
   localparam logic [1:0] OP_KEY_LOAD = 2'd0;
   localparam logic [1:0] OP_SCHEDULE = 2'd1;
   localparam logic [1:0] OP_DATA     = 2'd2;

   // Register index, taken from the word address bit.
   localparam logic REG_KEY_LENGTH = 1'b0;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_D1,
      ST_D2,
      ST_D3,
      ST_D4,
      ST_FILL,
      ST_K0,
      ST_K1,
      ST_K2,
      ST_K3,
      ST_K4
   } state_type;

   typedef struct packed {
      logic              we;
      logic [SBOX_AW-1:0] waddr;
      logic [BYTE_W-1:0]  wdata;
      logic [SBOX_AW-1:0] raddr;
   } ram_ctl_type;

endpackage

### rtl/rc4_stream_cipher.sv
// RC4 stream cipher top level.
// Usage: items enter on the req_ channel (valid/stall), results leave on the
// rsp_ channel, and the key length register sits on the APB port at byte
// address 0. Opcode 0 stores a key byte, opcode 1 runs the key schedule,
// opcode 2 XORs one data byte with the next keystream byte.
// Key byte load: no result, and req_stall stays low.
// Key schedule: req_stall stays high after acceptance while ST_FILL fills the
// S-box and then each swap step runs through ST_K0 to ST_K4; no result.
// Data byte: after acceptance the block runs ST_D1 to ST_D4 and registers
// the result; the next item waits for ST_IDLE. This order is set by the
// single registered read port of the S-box RAM, which needs three reads and
// two writes in sequence. Opcode 3 is dropped with no result.
// After reset the S-box is cleared to zero, one entry a cycle, over all 256
// entries; req_stall stays high meanwhile. i and j start at zero.
// A finished result waits in the output register while rsp_stall is high;
// the next item is still accepted, and a data byte that finishes while the
// register is full holds in its last step until the register drains.
module rc4_stream_cipher #(
   parameter int KEY_STORE_DEPTH = 256
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_opcode,
   input  logic [7:0]                 req_key_index,
   input  logic [7:0]                 req_key_byte,
   input  logic [7:0]                 req_data_byte,
   input  logic                       req_end_of_message,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [7:0]                 rsp_out_byte,
   output logic                       rsp_end_of_message_out,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [rc4_pkg::CSR_AW-1:0] paddr,
   input  logic [rc4_pkg::CSR_DW-1:0] pwdata,
   output logic [rc4_pkg::CSR_DW-1:0] prdata,
   output logic                       pready
);
   import rc4_pkg::*;

   localparam int KEY_AW = (KEY_STORE_DEPTH > 1) ? $clog2(KEY_STORE_DEPTH) : 1;

   logic [KEY_LEN_W-1:0] eff_len;
   ram_ctl_type          sbox_ctl;
   logic [BYTE_W-1:0]    sbox_rdata;
   logic                 key_we;
   logic [KEY_AW-1:0]    key_waddr;
   logic [BYTE_W-1:0]    key_wdata;
   logic [KEY_AW-1:0]    key_raddr;
   logic [BYTE_W-1:0]    key_rdata;

   rc4_csr #(
      .KEY_STORE_DEPTH(KEY_STORE_DEPTH)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .eff_len (eff_len)
   );

   rc4_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (1 << SBOX_AW),
      .AW    (SBOX_AW)
   ) u_sbox (
      .clock (clock),
      .we    (sbox_ctl.we),
      .waddr (sbox_ctl.waddr),
      .wdata (sbox_ctl.wdata),
      .raddr (sbox_ctl.raddr),
      .rdata (sbox_rdata)
   );

   rc4_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (KEY_STORE_DEPTH),
      .AW    (KEY_AW)
   ) u_key (
      .clock (clock),
      .we    (key_we),
      .waddr (key_waddr),
      .wdata (key_wdata),
      .raddr (key_raddr),
      .rdata (key_rdata)
   );

   rc4_seq #(
      .KEY_STORE_DEPTH (KEY_STORE_DEPTH),
      .KEY_AW          (KEY_AW)
   ) u_seq (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_opcode             (req_opcode),
      .req_key_index          (req_key_index),
      .req_key_byte           (req_key_byte),
      .req_data_byte          (req_data_byte),
      .req_end_of_message     (req_end_of_message),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_out_byte           (rsp_out_byte),
      .rsp_end_of_message_out (rsp_end_of_message_out),
      .eff_len                (eff_len),
      .sbox_ctl               (sbox_ctl),
      .sbox_rdata             (sbox_rdata),
      .key_we                 (key_we),
      .key_waddr              (key_waddr),
      .key_wdata              (key_wdata),
      .key_raddr              (key_raddr),
      .key_rdata              (key_rdata)
   );

`ifndef SYNTHESIS
   // The S-box clearing pass keeps the input side closed right after reset.
   a_clear_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> req_stall)
      else $error("input accepted during the S-box clearing pass");

   // The key store is written only by an item taken while idle.
   a_key_write_idle: assert property (@(posedge clock) disable iff (reset)
      key_we |-> (!req_stall && req_valid && (req_opcode == OP_KEY_LOAD)))
      else $error("key store written outside a key load item");

   // A new result only follows a busy data step.
   a_result_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a data step");
`endif

endmodule

### rtl/rc4_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rc4_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/rc4_csr.sv
// Configuration register file: key length register and its clamped value.
module rc4_csr #(
   parameter int KEY_STORE_DEPTH = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [rc4_pkg::CSR_AW-1:0]    paddr,
   input  logic [rc4_pkg::CSR_DW-1:0]    pwdata,
   output logic [rc4_pkg::CSR_DW-1:0]    prdata,
   output logic                          pready,
   output logic [rc4_pkg::KEY_LEN_W-1:0] eff_len
);
   import rc4_pkg::*;

   localparam logic [KEY_LEN_W-1:0] DEPTH_LEN = KEY_LEN_W'(KEY_STORE_DEPTH);

   logic [KEY_LEN_W-1:0] key_length_ff;
   logic [KEY_LEN_W-1:0] key_length_in;
   logic                 wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_KEY_LENGTH);

   always_comb begin
      key_length_in = key_length_ff;
      if (wr_hit) begin
         key_length_in = pwdata[KEY_LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_length_ff <= KEY_LEN_RESET;
      end else begin
         key_length_ff <= key_length_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_KEY_LENGTH) begin
         prdata = {{(CSR_DW-KEY_LEN_W){1'b0}}, key_length_ff};
      end
   end

   // A length of zero acts as one; a length beyond the key store is cut to its depth.
   always_comb begin
      if (key_length_ff == '0) begin
         eff_len = KEY_LEN_W'(1);
      end else if (key_length_ff > DEPTH_LEN) begin
         eff_len = DEPTH_LEN;
      end else begin
         eff_len = key_length_ff;
      end
   end

endmodule

### rtl/rc4_seq.sv
// Sequencer and shared byte adder for key load, key schedule and data steps.
module rc4_seq #(
   parameter int KEY_STORE_DEPTH = 256,
   parameter int KEY_AW = (KEY_STORE_DEPTH > 1) ? $clog2(KEY_STORE_DEPTH) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_opcode,
   input  logic [7:0]                    req_key_index,
   input  logic [7:0]                    req_key_byte,
   input  logic [7:0]                    req_data_byte,
   input  logic                          req_end_of_message,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_out_byte,
   output logic                          rsp_end_of_message_out,
   input  logic [rc4_pkg::KEY_LEN_W-1:0] eff_len,
   output rc4_pkg::ram_ctl_type          sbox_ctl,
   input  logic [rc4_pkg::BYTE_W-1:0]    sbox_rdata,
   output logic                          key_we,
   output logic [KEY_AW-1:0]             key_waddr,
   output logic [rc4_pkg::BYTE_W-1:0]    key_wdata,
   output logic [KEY_AW-1:0]             key_raddr,
   input  logic [rc4_pkg::BYTE_W-1:0]    key_rdata
);
   import rc4_pkg::*;

   localparam logic [KEY_LEN_W-1:0] DEPTH_LEN = KEY_LEN_W'(KEY_STORE_DEPTH);
   localparam logic [SBOX_AW-1:0]   LAST_N    = '1;

   state_type state_ff, state_in;

   logic [BYTE_W-1:0]  i_ff, i_in;
   logic [BYTE_W-1:0]  j_ff, j_in;
   logic [SBOX_AW-1:0] n_ff, n_in;
   logic [KEY_AW-1:0]  kidx_ff, kidx_in;
   logic [BYTE_W-1:0]  si_ff, si_in;
   logic [BYTE_W-1:0]  sum_ff, sum_in;
   logic [BYTE_W-1:0]  kbyte_ff, kbyte_in;
   logic [BYTE_W-1:0]  data_ff, data_in;
   logic               eom_ff, eom_in;
   logic               byp_ff, byp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]  out_byte_ff, out_byte_in;
   logic               out_eom_ff, out_eom_in;

   logic [BYTE_W-1:0]    add_a, add_b, add_y;
   logic [KEY_LEN_W-1:0] kidx_next;
   logic                 accept;
   logic                 out_free;
   logic [BYTE_W-1:0]    keystream;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Key bytes land directly from the input item; indexes past the store are dropped.
   assign key_we    = accept && (req_opcode == OP_KEY_LOAD)
                      && ({1'b0, req_key_index} < DEPTH_LEN);
   assign key_waddr = req_key_index[KEY_AW-1:0];
   assign key_wdata = req_key_byte;
   assign key_raddr = kidx_ff;

   assign kidx_next = {{(KEY_LEN_W-KEY_AW){1'b0}}, kidx_ff} + KEY_LEN_W'(1);
   assign keystream = byp_ff ? si_ff : sbox_rdata;

   // The one byte adder, shared by the i and j updates and every sum update.
   always_comb begin
      add_a = j_ff;
      add_b = sbox_rdata;
      case (state_ff)
         ST_IDLE: begin
            add_a = i_ff;
            add_b = BYTE_W'(1);
         end
         ST_D2: begin
            add_a = si_ff;
            add_b = sbox_rdata;
         end
         ST_K2: begin
            add_a = sum_ff;
            add_b = kbyte_ff;
         end
         default: begin
            add_a = j_ff;
            add_b = sbox_rdata;
         end
      endcase
   end

   assign add_y = add_a + add_b;

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      n_in         = n_ff;
      kidx_in      = kidx_ff;
      si_in        = si_ff;
      sum_in       = sum_ff;
      kbyte_in     = kbyte_ff;
      data_in      = data_ff;
      eom_in       = eom_ff;
      byp_in       = byp_ff;
      out_byte_in  = out_byte_ff;
      out_eom_in   = out_eom_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      sbox_ctl     = '{we: 1'b0, waddr: n_ff, wdata: '0, raddr: sum_ff};

      case (state_ff)
         ST_CLEAR: begin
            sbox_ctl.we    = 1'b1;
            sbox_ctl.waddr = n_ff;
            sbox_ctl.wdata = '0;
            n_in           = n_ff + SBOX_AW'(1);
            if (n_ff == LAST_N) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            sbox_ctl.raddr = add_y;
            if (accept) begin
               case (req_opcode)
                  OP_SCHEDULE: begin
                     n_in     = '0;
                     state_in = ST_FILL;
                  end
                  OP_DATA: begin
                     i_in     = add_y;
                     data_in  = req_data_byte;
                     eom_in   = req_end_of_message;
                     state_in = ST_D1;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_D1: begin
            si_in          = sbox_rdata;
            j_in           = add_y;
            sbox_ctl.raddr = add_y;
            state_in       = ST_D2;
         end
         ST_D2: begin
            sbox_ctl.we    = 1'b1;
            sbox_ctl.waddr = i_ff;
            sbox_ctl.wdata = sbox_rdata;
            sum_in         = add_y;
            state_in       = ST_D3;
         end
         ST_D3: begin
            // The read of S[i]+S[j] races the write of S[j]; a match takes the written byte.
            sbox_ctl.we    = 1'b1;
            sbox_ctl.waddr = j_ff;
            sbox_ctl.wdata = si_ff;
            sbox_ctl.raddr = sum_ff;
            byp_in         = (sum_ff == j_ff);
            state_in       = ST_D4;
         end
         ST_D4: begin
            sbox_ctl.raddr = sum_ff;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_byte_in  = data_ff ^ keystream;
               out_eom_in   = eom_ff;
               state_in     = ST_IDLE;
            end
         end
         ST_FILL: begin
            sbox_ctl.we    = 1'b1;
            sbox_ctl.waddr = n_ff;
            sbox_ctl.wdata = n_ff;
            n_in           = n_ff + SBOX_AW'(1);
            if (n_ff == LAST_N) begin
               j_in     = '0;
               kidx_in  = '0;
               state_in = ST_K0;
            end
         end
         ST_K0: begin
            sbox_ctl.raddr = n_ff;
            state_in       = ST_K1;
         end
         ST_K1: begin
            si_in    = sbox_rdata;
            kbyte_in = key_rdata;
            sum_in   = add_y;
            state_in = ST_K2;
         end
         ST_K2: begin
            j_in           = add_y;
            sbox_ctl.raddr = add_y;
            state_in       = ST_K3;
         end
         ST_K3: begin
            sbox_ctl.we    = 1'b1;
            sbox_ctl.waddr = n_ff;
            sbox_ctl.wdata = sbox_rdata;
            state_in       = ST_K4;
         end
         ST_K4: begin
            sbox_ctl.we    = 1'b1;
            sbox_ctl.waddr = j_ff;
            sbox_ctl.wdata = si_ff;
            n_in           = n_ff + SBOX_AW'(1);
            if (kidx_next == eff_len) begin
               kidx_in = '0;
            end else begin
               kidx_in = kidx_next[KEY_AW-1:0];
            end
            if (n_ff == LAST_N) begin
               i_in     = '0;
               j_in     = '0;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_K0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         i_ff         <= '0;
         j_ff         <= '0;
         n_ff         <= '0;
         kidx_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         n_ff         <= n_in;
         kidx_ff      <= kidx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      si_ff       <= si_in;
      sum_ff      <= sum_in;
      kbyte_ff    <= kbyte_in;
      data_ff     <= data_in;
      eom_ff      <= eom_in;
      byp_ff      <= byp_in;
      out_byte_ff <= out_byte_in;
      out_eom_ff  <= out_eom_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_out_byte           = out_byte_ff;
   assign rsp_end_of_message_out = out_eom_ff;

endmodule

### tb/rc4_stream_cipher_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the RC4 stream cipher: keyed traffic against a byte-level predictor.
module rc4_stream_cipher_tb;
   import rc4_pkg::*;

   localparam int KEY_DEPTH = 256;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [CSR_AW-1:0] KEY_LENGTH_ADDR = {REG_KEY_LENGTH, 2'b00};
   localparam int ITEM_TARGET = 1600;
   localparam int DRAIN_CYCLES = 1600;
   localparam int STALL_LIMIT = 20000;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] key_index;
      logic [7:0] key_byte;
      logic [7:0] data_byte;
      logic       eom;
   } cipher_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       eom;
   } cipher_result_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_opcode = '0;
   logic [7:0] req_key_index = '0;
   logic [7:0] req_key_byte = '0;
   logic [7:0] req_data_byte = '0;
   logic req_end_of_message = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic rsp_end_of_message_out;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_AW-1:0] paddr = '0;
   logic [CSR_DW-1:0] pwdata = '0;
   logic [CSR_DW-1:0] prdata;
   logic pready;

   cipher_item_type req_backlog[$];
   cipher_result_type ciphertext_due[$];
   bit key_seen [KEY_DEPTH];
   int items_counted = 0;
   int fail_count = 0;
   int quiet_cycles = 0;
   int send_gap = 0;
   int send_calm = 0;
   int stall_left = 0;
   int rsp_calm = 0;
   bit req_taken = 1'b0;

   // Predictor state.
   logic [7:0] sbox_model [256];
   logic [7:0] key_mem [KEY_DEPTH];
   logic [7:0] ptr_i;
   logic [7:0] ptr_j;
   logic [KEY_LEN_W-1:0] key_len_reg;

   rc4_stream_cipher #(.KEY_STORE_DEPTH(KEY_DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_opcode(req_opcode),
      .req_key_index(req_key_index),
      .req_key_byte(req_key_byte),
      .req_data_byte(req_data_byte),
      .req_end_of_message(req_end_of_message),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte),
      .rsp_end_of_message_out(rsp_end_of_message_out),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) $display("ERROR: %s", msg);
   endfunction

   function automatic void rekey_sbox();
      int len;
      logic [7:0] jj;
      logic [7:0] swap_byte;
      len = int'(key_len_reg);
      if (len < 1) len = 1;
      if (len > KEY_DEPTH) len = KEY_DEPTH;
      for (int n = 0; n < 256; n++) sbox_model[n] = 8'(n);
      jj = 8'd0;
      for (int n = 0; n < 256; n++) begin
         jj = jj + sbox_model[n] + key_mem[n % len];
         swap_byte = sbox_model[n];
         sbox_model[n] = sbox_model[jj];
         sbox_model[jj] = swap_byte;
      end
      ptr_i = 8'd0;
      ptr_j = 8'd0;
   endfunction

   function automatic logic [7:0] advance_keystream();
      logic [7:0] swap_byte;
      logic [7:0] pick;
      ptr_i = ptr_i + 8'd1;
      ptr_j = ptr_j + sbox_model[ptr_i];
      swap_byte = sbox_model[ptr_i];
      sbox_model[ptr_i] = sbox_model[ptr_j];
      sbox_model[ptr_j] = swap_byte;
      pick = sbox_model[ptr_i] + sbox_model[ptr_j];
      return sbox_model[pick];
   endfunction

   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 15);
      return $urandom_range(30, 150);
   endfunction

   function automatic logic [7:0] rand_byte();
      return 8'($urandom);
   endfunction

   function automatic void queue_item(input logic [1:0] op, input logic [7:0] idx,
                                      input logic [7:0] kb, input logic [7:0] db,
                                      input logic eom);
      cipher_item_type item;
      item.opcode = op;
      item.key_index = idx;
      item.key_byte = kb;
      item.data_byte = db;
      item.eom = eom;
      req_backlog.push_back(item);
      if (op != OP_UNUSED) items_counted++;
      if (op == OP_KEY_LOAD) key_seen[idx] = 1'b1;
   endfunction

   // Accepted items update the predictor in the order the block sees them.
   always @(posedge clock) begin : predict_req
      cipher_result_type result;
      if (!reset && req_valid && !req_stall) begin
         req_taken = 1'b1;
         case (req_opcode)
            OP_KEY_LOAD: begin
               if (req_key_index < KEY_DEPTH) key_mem[req_key_index] = req_key_byte;
            end
            OP_SCHEDULE: begin
               rekey_sbox();
            end
            OP_DATA: begin
               result.out_byte = req_data_byte ^ advance_keystream();
               result.eom = req_end_of_message;
               ciphertext_due.push_back(result);
            end
            default: begin
            end
         endcase
      end
   end

   always @(posedge clock) begin : check_rsp
      cipher_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (ciphertext_due.size() == 0) begin
            note_failure($sformatf("unexpected result %02h/%0b", rsp_out_byte,
                                   rsp_end_of_message_out));
         end else begin
            want = ciphertext_due.pop_front();
            if (rsp_out_byte !== want.out_byte || rsp_end_of_message_out !== want.eom) begin
               note_failure($sformatf("out_byte/eom expected %02h/%0b, got %02h/%0b",
                                      want.out_byte, want.eom, rsp_out_byte,
                                      rsp_end_of_message_out));
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("rc4_stream_cipher_tb NOT OK");
         $finish;
      end
   end

   always @(negedge clock) begin : drive_req
      cipher_item_type next_item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_taken) begin
            req_taken = 1'b0;
            if (send_calm > 0) begin
               send_calm--;
               send_gap = 0;
            end else begin
               if ($urandom_range(0, 99) < 3) send_calm = $urandom_range(20, 80);
               send_gap = idle_length();
            end
         end
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (req_backlog.size() != 0) begin
            next_item = req_backlog.pop_front();
            req_opcode <= next_item.opcode;
            req_key_index <= next_item.key_index;
            req_key_byte <= next_item.key_byte;
            req_data_byte <= next_item.data_byte;
            req_end_of_message <= next_item.eom;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : drive_rsp_stall
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (rsp_calm > 0) rsp_calm--;
         else if ($urandom_range(0, 99) < 2) rsp_calm = $urandom_range(30, 100);
         else stall_left = idle_length();
      end
   end

   // Writes the key length with random upper bits, then reads it back.
   task automatic write_key_length(input logic [KEY_LEN_W-1:0] len);
      logic [CSR_DW-1:0] word;
      word = $urandom;
      word[KEY_LEN_W-1:0] = len;
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= KEY_LENGTH_ADDR;
      pwdata <= word;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      key_len_reg = len;
      @(negedge clock);
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata[KEY_LEN_W-1:0] !== len) begin
         note_failure($sformatf("key_length read expected %0d, got %0d", len,
                                prdata[KEY_LEN_W-1:0]));
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic drain_results(input int extra);
      while (req_backlog.size() != 0 || req_valid || ciphertext_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (extra) @(posedge clock);
   endtask

   // Well-formed messages (load key, schedule, data) with some noise mixed in.
   task automatic run_phase(input int eff_len);
      int messages;
      int n;
      int idx;
      bit descending;
      bit fresh;
      messages = $urandom_range(1, 4);
      for (int m = 0; m < messages; m++) begin
         if (m == 0) begin
            descending = $urandom_range(0, 1);
            fresh = (eff_len <= 32) && ($urandom_range(0, 1) == 1);
            for (int k = 0; k < eff_len; k++) begin
               idx = descending ? eff_len - 1 - k : k;
               if (fresh || !key_seen[idx]) queue_item(OP_KEY_LOAD, 8'(idx), rand_byte(),
                                                       rand_byte(), 1'($urandom));
            end
         end
         repeat ($urandom_range(0, 3)) begin
            queue_item(OP_KEY_LOAD, 8'($urandom_range(0, eff_len - 1)), rand_byte(),
                       rand_byte(), 1'($urandom));
         end
         // Now and then the keystream simply carries on without a new schedule.
         if (m == 0 || $urandom_range(0, 9) != 0) begin
            queue_item(OP_SCHEDULE, rand_byte(), rand_byte(), rand_byte(), 1'($urandom));
         end
         n = $urandom_range(1, 60);
         for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < 8) begin
               case ($urandom_range(0, 2))
                  0: queue_item(OP_UNUSED, rand_byte(), rand_byte(), rand_byte(),
                                1'($urandom));
                  1: queue_item(OP_KEY_LOAD, rand_byte(), rand_byte(), rand_byte(),
                                1'($urandom));
                  default: queue_item(OP_SCHEDULE, rand_byte(), rand_byte(), rand_byte(),
                                      1'($urandom));
               endcase
            end
            queue_item(OP_DATA, rand_byte(), rand_byte(), rand_byte(),
                       (k == n - 1) || ($urandom_range(0, 19) == 0));
         end
         if ($urandom_range(0, 6) == 0) drain_results(0);
      end
   endtask

   initial begin : stimulus
      int phase;
      int eff_len;
      logic [KEY_LEN_W-1:0] len;
      for (int n = 0; n < 256; n++) sbox_model[n] = 8'd0;
      for (int n = 0; n < KEY_DEPTH; n++) key_mem[n] = 8'd0;
      ptr_i = 8'd0;
      ptr_j = 8'd0;
      key_len_reg = KEY_LEN_RESET;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_key_length(9'd1);
      // Data on the cleared S-box passes through unchanged.
      queue_item(OP_DATA, 8'h00, 8'h00, 8'h00, 1'b0);
      queue_item(OP_DATA, 8'hFF, 8'hFF, 8'hFF, 1'b1);
      queue_item(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 1'b1);
      queue_item(OP_UNUSED, 8'h00, 8'h00, 8'h00, 1'b0);
      queue_item(OP_KEY_LOAD, 8'hFF, 8'hFF, 8'h00, 1'b0);
      queue_item(OP_KEY_LOAD, 8'h00, 8'h00, 8'hFF, 1'b1);
      queue_item(OP_SCHEDULE, 8'h00, 8'h00, 8'h00, 1'b0);
      queue_item(OP_DATA, 8'h00, 8'hFF, 8'h00, 1'b0);
      queue_item(OP_DATA, 8'hFF, 8'h00, 8'hFF, 1'b0);
      queue_item(OP_UNUSED, 8'h5A, 8'hA5, 8'h3C, 1'b0);
      queue_item(OP_DATA, 8'h00, 8'h00, 8'hA5, 1'b1);
      // A key change without a new schedule must not disturb the keystream.
      queue_item(OP_KEY_LOAD, 8'h00, 8'hFF, 8'h00, 1'b0);
      queue_item(OP_KEY_LOAD, 8'h80, 8'h80, 8'h00, 1'b0);
      queue_item(OP_DATA, 8'h00, 8'h00, 8'h5A, 1'b0);
      queue_item(OP_SCHEDULE, 8'hFF, 8'hFF, 8'hFF, 1'b1);
      queue_item(OP_DATA, 8'h00, 8'h00, 8'h00, 1'b0);
      queue_item(OP_DATA, 8'h00, 8'h00, 8'hFF, 1'b1);
      queue_item(OP_SCHEDULE, 8'h00, 8'h00, 8'h00, 1'b0);
      queue_item(OP_SCHEDULE, 8'h00, 8'h00, 8'h00, 1'b0);
      queue_item(OP_DATA, 8'h00, 8'h00, 8'h3C, 1'b1);

      phase = 0;
      while (items_counted < ITEM_TARGET) begin
         drain_results(DRAIN_CYCLES);
         case (phase)
            0: len = 9'd0;
            1: len = 9'd256;
            2: len = 9'd2;
            3: len = 9'd511;
            4: len = 9'd16;
            5: len = 9'd300;
            6: len = 9'd3;
            7: len = 9'd255;
            default: begin
               if ($urandom_range(0, 3) == 0) len = KEY_LEN_W'($urandom_range(0, 511));
               else len = KEY_LEN_W'($urandom_range(1, 24));
            end
         endcase
         write_key_length(len);
         eff_len = (len == 0) ? 1 : ((len > KEY_DEPTH) ? KEY_DEPTH : int'(len));
         run_phase(eff_len);
         phase++;
      end
      drain_results(DRAIN_CYCLES);

      if (fail_count == 0) begin
         $display("rc4_stream_cipher_tb OK");
      end else begin
         $display("rc4_stream_cipher_tb NOT OK");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/rc4_pkg.sv
rtl/rc4_ram.sv
rtl/rc4_csr.sv
rtl/rc4_seq.sv
rtl/rc4_stream_cipher.sv
tb/rc4_stream_cipher_tb.sv
